>>> design/polyphase_rational_resampler_macros.svh
// assertion helpers for the resampler, clocked on clk and held off by rst_n
`ifndef POLYPHASE_RATIONAL_RESAMPLER_MACROS_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/prr_pkg.sv
`default_nettype none

package prr_pkg;

  // default sizing
  localparam int MAX_PHASES_DEF = 32;
  localparam int MAX_TAPS_DEF   = 32;

  // tap store
  localparam int TAP_AW    = 10;
  localparam int TAP_DEPTH = 1 << TAP_AW;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int TAP_W     = 18;
  localparam int PROD_W    = SAMPLE_W + TAP_W;
  localparam int PHASE_W   = 5;
  localparam int PC_W      = 7;
  localparam int IFACT_W   = 6;
  localparam int DFACT_W   = 7;
  localparam int TFACT_W   = 6;
  localparam int FRAC_BITS = 15;

  localparam int DECIM_LIMIT = 64;
  localparam int SAT_HI      = 32767;
  localparam int SAT_LO      = -32768;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd2;

  // input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TAP    = 1'b1;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic zero;
    logic clear;
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> design/prr_in_if.sv
`default_nettype none

interface prr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [prr_pkg::SAMPLE_W-1:0] sample;
  logic        [prr_pkg::TAP_AW-1:0]   tap_index;
  logic signed [prr_pkg::TAP_W-1:0]    tap_value;

  modport source (output valid, command, sample, tap_index, tap_value, input ready);
  modport sink   (input valid, command, sample, tap_index, tap_value, output ready);
endinterface

`default_nettype wire

>>> design/prr_out_if.sv
`default_nettype none

interface prr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [prr_pkg::SAMPLE_W-1:0] out_sample;
  logic        [prr_pkg::PHASE_W-1:0]  phase_used;
  logic                                last;

  modport source (output valid, out_sample, phase_used, last, input ready);
  modport sink   (input valid, out_sample, phase_used, last, output ready);
endinterface

`default_nettype wire

>>> design/prr_mac.sv
`default_nettype none

module prr_mac #(
  parameter int MAX_TAPS_PER_PHASE = prr_pkg::MAX_TAPS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire prr_pkg::mac_ctl_t                   ctl,
  input  wire logic signed [prr_pkg::SAMPLE_W-1:0] sample,
  input  wire logic signed [prr_pkg::TAP_W-1:0]    tap,
  output logic                                     busy,
  output logic signed [prr_pkg::SAMPLE_W-1:0]      result
);

  localparam int PROD_W = prr_pkg::PROD_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS_PER_PHASE) + 1;
  localparam int SH_W   = ACC_W - prr_pkg::FRAC_BITS;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(prr_pkg::SAT_HI);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(prr_pkg::SAT_LO);

  logic signed [prr_pkg::TAP_W-1:0] tap_eff;
  logic signed [PROD_W-1:0]         prod_r;
  logic                             prod_valid_r;
  logic signed [ACC_W-1:0]          acc_r;
  logic signed [SH_W-1:0]           shifted;

  // taps past the end of the store count as zero
  assign tap_eff = ctl.zero ? '0 : tap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(sample) * PROD_W'(tap_eff);
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_valid_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // floor shift, then saturate to q1.15
  assign shifted = acc_r[ACC_W-1:prr_pkg::FRAC_BITS];

  always_comb begin
    if (shifted > SAT_HI) begin
      result = prr_pkg::SAMPLE_W'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      result = prr_pkg::SAMPLE_W'(SAT_LO);
    end else begin
      result = prr_pkg::SAMPLE_W'(shifted);
    end
  end

  assign busy = prod_valid_r;

endmodule

`default_nettype wire

>>> design/polyphase_rational_resampler.sv
// polyphase rational resampler, interpolate by I and decimate by D
//
// in_ch carries one transaction per command: a tap write (command 1) stores
// tap_value at tap_index of the prototype filter, a sample (command 0) enters
// the delay line and produces zero or more results on out_ch, the final one
// marked by last. cfg_we/cfg_index/cfg_data set I, D and taps per phase T;
// write them only while the block is idle.
// a tap write or a sample without results leaves the sequencer idle. for each
// result of a sample, one shared 16x18 multiplier walks the T taps of the
// branch one per cycle, then the read, product and accumulate stages drain
// and the result is handed to the output register.
// in_ch.ready is high only between samples.
// reset clears the delay line, the phase counter and the output valid flag and
// sets I = D = T = 1; tap memory holds garbage until written.
// a stalled receiver holds the result in the output register; the next
// output's taps are accumulated meanwhile, then the sequencer waits for room.
`default_nettype none

`include "polyphase_rational_resampler_macros.svh"

module polyphase_rational_resampler #(
  parameter int MAX_PHASES         = prr_pkg::MAX_PHASES_DEF,
  parameter int MAX_TAPS_PER_PHASE = prr_pkg::MAX_TAPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  prr_in_if.sink                                in_ch,
  prr_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [prr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [prr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PC_W   = prr_pkg::PC_W;
  localparam int TW     = $clog2(MAX_TAPS_PER_PHASE + 1);
  localparam int DW     = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1;
  localparam int TCMP_W = (TW > prr_pkg::TFACT_W) ? TW : prr_pkg::TFACT_W;
  localparam int KRAW_W = $clog2(MAX_PHASES * MAX_TAPS_PER_PHASE) + 1;
  localparam int KW     = (KRAW_W > prr_pkg::TAP_AW) ? KRAW_W : prr_pkg::TAP_AW + 1;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  // configuration registers
  logic [prr_pkg::IFACT_W-1:0] cfg_interp_r;
  logic [prr_pkg::DFACT_W-1:0] cfg_decim_r;
  logic [prr_pkg::TFACT_W-1:0] cfg_taps_r;

  // effective (clamped) factors
  logic [PC_W-1:0]               ni_w;
  logic [prr_pkg::DFACT_W-1:0]   nd_w;
  logic [TW-1:0]                 nt_w;

  // sequencer
  logic [1:0]      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [PC_W-1:0] pc_sum;
  logic [TW-1:0]   j_r, j_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            issue;
  logic            acc_clear;
  logic            emit_fire;
  logic            last_w;
  logic            in_fire;
  logic            out_free;

  // storage
  logic signed [prr_pkg::SAMPLE_W-1:0] delay_r [MAX_TAPS_PER_PHASE];
  logic signed [prr_pkg::TAP_W-1:0]    tap_mem [prr_pkg::TAP_DEPTH];
  logic signed [prr_pkg::TAP_W-1:0]    tap_rd_r;

  // read stage into the multiplier
  logic                                s1_valid_r;
  logic                                s1_zero_r;
  logic signed [prr_pkg::SAMPLE_W-1:0] s1_sample_r;

  // multiply-accumulate unit
  prr_pkg::mac_ctl_t                   mac_ctl;
  logic                                mac_busy;
  logic signed [prr_pkg::SAMPLE_W-1:0] mac_result;

  // output register
  logic                                out_valid_r;
  logic signed [prr_pkg::SAMPLE_W-1:0] out_sample_r;
  logic [prr_pkg::PHASE_W-1:0]         out_phase_r;
  logic                                out_last_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_interp_r <= prr_pkg::IFACT_W'(1);
      cfg_decim_r  <= prr_pkg::DFACT_W'(1);
      cfg_taps_r   <= prr_pkg::TFACT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        prr_pkg::CFG_INTERP: cfg_interp_r <= cfg_data[prr_pkg::IFACT_W-1:0];
        prr_pkg::CFG_DECIM:  cfg_decim_r  <= cfg_data[prr_pkg::DFACT_W-1:0];
        prr_pkg::CFG_TAPS:   cfg_taps_r   <= cfg_data[prr_pkg::TFACT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, large values stop at the limit
  always_comb begin
    if (cfg_interp_r == '0) begin
      ni_w = PC_W'(1);
    end else if (PC_W'(cfg_interp_r) > PC_W'(MAX_PHASES)) begin
      ni_w = PC_W'(MAX_PHASES);
    end else begin
      ni_w = PC_W'(cfg_interp_r);
    end

    if (cfg_decim_r == '0) begin
      nd_w = prr_pkg::DFACT_W'(1);
    end else if (cfg_decim_r > prr_pkg::DFACT_W'(prr_pkg::DECIM_LIMIT)) begin
      nd_w = prr_pkg::DFACT_W'(prr_pkg::DECIM_LIMIT);
    end else begin
      nd_w = cfg_decim_r;
    end

    if (cfg_taps_r == '0) begin
      nt_w = TW'(1);
    end else if (TCMP_W'(cfg_taps_r) > TCMP_W'(MAX_TAPS_PER_PHASE)) begin
      nt_w = TW'(MAX_TAPS_PER_PHASE);
    end else begin
      nt_w = TW'(cfg_taps_r);
    end
  end

  // phase counter plus decimation step, always below 2^PC_W
  assign pc_sum = pc_r + PC_W'(nd_w);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    issue     = 1'b0;
    acc_clear = 1'b0;
    emit_fire = 1'b0;
    last_w    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.command == prr_pkg::CMD_SAMPLE)) begin
          if (pc_r < ni_w) begin
            state_nxt = S_MAC;
            j_nxt     = '0;
            k_nxt     = KW'(pc_r);
            acc_clear = 1'b1;
          end else begin
            // no output for this sample
            pc_nxt = pc_r - ni_w;
          end
        end
      end
      S_MAC: begin
        // one tap of branch pc_r per cycle, prototype index steps by I
        issue = 1'b1;
        j_nxt = j_r + TW'(1);
        k_nxt = k_r + KW'(ni_w);
        if (j_r == nt_w - TW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_valid_r && !mac_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit_fire = 1'b1;
          last_w    = (pc_sum >= ni_w);
          if (last_w) begin
            pc_nxt    = pc_sum - ni_w;
            state_nxt = S_IDLE;
          end else begin
            pc_nxt    = pc_sum;
            j_nxt     = '0;
            k_nxt     = KW'(pc_sum);
            acc_clear = 1'b1;
            state_nxt = S_MAC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
    j_r <= j_nxt;
    k_r <= k_nxt;
  end

  // delay line, newest sample at position 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS_PER_PHASE; i++) begin
        delay_r[i] <= '0;
      end
    end else if (in_fire && (in_ch.command == prr_pkg::CMD_SAMPLE)) begin
      delay_r[0] <= in_ch.sample;
      for (int i = 1; i < MAX_TAPS_PER_PHASE; i++) begin
        delay_r[i] <= delay_r[i-1];
      end
    end
  end

  // prototype tap memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.command == prr_pkg::CMD_TAP)) begin
      tap_mem[in_ch.tap_index] <= in_ch.tap_value;
    end
    tap_rd_r <= tap_mem[k_r[prr_pkg::TAP_AW-1:0]];
  end

  // read stage, lines up the sample with the tap memory output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
    s1_zero_r   <= (k_r >= KW'(prr_pkg::TAP_DEPTH));
    s1_sample_r <= delay_r[j_r[DW-1:0]];
  end

  assign mac_ctl.valid = s1_valid_r;
  assign mac_ctl.zero  = s1_zero_r;
  assign mac_ctl.clear = acc_clear;

  prr_mac #(
    .MAX_TAPS_PER_PHASE(MAX_TAPS_PER_PHASE)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .sample (s1_sample_r),
    .tap    (tap_rd_r),
    .busy   (mac_busy),
    .result (mac_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (emit_fire) begin
      out_sample_r <= mac_result;
      out_phase_r  <= pc_r[prr_pkg::PHASE_W-1:0];
      out_last_r   <= last_w;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_sample = out_sample_r;
  assign out_ch.phase_used = out_phase_r;
  assign out_ch.last       = out_last_r;

  // a branch is only walked while the phase counter is below I
  `PRR_ASSERT_NOW(a_phase_in_range, (state_r == S_MAC), (pc_r < ni_w),
                  "phase counter not below interpolation factor during accumulate")

  // tap walk stops at taps per phase
  `PRR_ASSERT_NOW(a_tap_walk_bound, (state_r == S_MAC), (j_r < nt_w),
                  "tap index ran past taps per phase")

  // the final result of a sample returns the sequencer to idle
  `PRR_ASSERT_NEXT(a_last_to_idle, (emit_fire && last_w),
                   (state_r == S_IDLE && out_ch.valid && out_ch.last),
                   "last result did not end the sample")

endmodule

`default_nettype wire

>>> tb/polyphase_rational_resampler_test.sv
module polyphase_rational_resampler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prr_pkg::*;

  localparam int HIST_DEPTH   = MAX_TAPS_DEF;
  localparam int MAX_BRANCHES = MAX_PHASES_DEF;
  // cycles a tap write or a silent sample may still keep the block busy
  localparam int SETTLE_CYCLES = 8;
  // quiet time after the last expected result, covers a full branch walk
  localparam int TAIL_CYCLES = 60;
  // longest correct gap is one branch walk plus a long receiver hold-off
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  // random settings keep the prototype that must be loaded this small
  localparam int RANDOM_REACH = 64;
  // index 3 maps to no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic [PHASE_W-1:0]         phase_used;
    logic                       last;
  } resampled_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic recv_ready = 1'b0;

  prr_in_if  in_ch ();
  prr_out_if out_ch ();

  assign out_ch.ready = recv_ready;

  polyphase_rational_resampler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: mirror of the delay line, prototype taps, phase counter and registers
  logic signed [SAMPLE_W-1:0] history [HIST_DEPTH];
  logic signed [TAP_W-1:0]    proto_taps [TAP_DEPTH];
  bit                         tap_known [TAP_DEPTH];
  int unsigned                phase_acc;
  logic [IFACT_W-1:0]         reg_interp;
  logic [DFACT_W-1:0]         reg_decim;
  logic [TFACT_W-1:0]         reg_taps;

  // results predicted but not yet seen on out_ch, oldest first
  resampled_t predicted_outputs [$];

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // out-of-range factors fold into the legal range, 0 acts as 1
  function automatic int unsigned clamp_factor(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // one sample: shift it into the history, emit every branch while the counter is below I
  task automatic advance_resampler(input logic signed [SAMPLE_W-1:0] smp);
    int unsigned ni, nd, nt, j, k, n_out;
    longint acc, q;
    resampled_t r;
    ni = clamp_factor(reg_interp, MAX_BRANCHES);
    nd = clamp_factor(reg_decim, DECIM_LIMIT);
    nt = clamp_factor(reg_taps, HIST_DEPTH);
    for (j = HIST_DEPTH - 1; j > 0; j--) history[j] = history[j-1];
    history[0] = smp;
    n_out = 0;
    while (phase_acc < ni && n_out < MAX_BRANCHES) begin
      acc = 0;
      // branch tap j sits at prototype index phase + j*I, tap 0 meets the newest sample
      for (j = 0; j < nt; j++) begin
        k = phase_acc + j * ni;
        if (k < TAP_DEPTH) acc += longint'(proto_taps[k]) * longint'(history[j]);
      end
      // arithmetic shift floors toward minus infinity, then clip to Q1.15
      q = acc >>> FRAC_BITS;
      if (q > SAT_HI) q = SAT_HI;
      else if (q < SAT_LO) q = SAT_LO;
      r.out_sample = q[SAMPLE_W-1:0];
      r.phase_used = phase_acc[PHASE_W-1:0];
      n_out++;
      phase_acc += nd;
      r.last = !(phase_acc < ni && n_out < MAX_BRANCHES);
      predicted_outputs.push_back(r);
    end
    if (phase_acc >= ni) phase_acc -= ni;
    else phase_acc = 0;
    phase_acc = phase_acc & 32'h7F;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic signed [TAP_W-1:0] random_tap();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: return 18'sh1FFFF;
        1: return 18'sh20000;
        2: return 18'sh00000;
        default: return 18'sh3FFFF;
      endcase
    end
    return TAP_W'($urandom);
  endfunction

  // one input transaction; valid stays high on return so back-to-back items need no gap
  task automatic send_item(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
                           input logic [TAP_AW-1:0] idx, input logic signed [TAP_W-1:0] tv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.sample    <= smp;
    in_ch.tap_index <= idx;
    in_ch.tap_value <= tv;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_TAP) begin
      proto_taps[idx] = tv;
      tap_known[idx] = 1'b1;
    end else begin
      advance_resampler(smp);
    end
  endtask

  // unused fields carry junk, the block must ignore them
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    send_item(CMD_SAMPLE, smp, TAP_AW'($urandom), TAP_W'($urandom));
  endtask

  task automatic send_tap(input logic [TAP_AW-1:0] idx, input logic signed [TAP_W-1:0] tv);
    send_item(CMD_TAP, SAMPLE_W'($urandom), idx, tv);
  endtask

  // stop offering, wait for every predicted result, then let the block settle
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes the prototype taps the current setting can reach and that were never written
  task automatic load_prototype();
    int unsigned reach, k;
    reach = clamp_factor(reg_interp, MAX_BRANCHES) * clamp_factor(reg_taps, HIST_DEPTH);
    if (reach > TAP_DEPTH) reach = TAP_DEPTH;
    for (k = 0; k < reach; k++)
      if (!tap_known[k]) send_tap(k[TAP_AW-1:0], random_tap());
  endtask

  // register writes back to back, enable lowered once at the end
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] interp, input logic [CFG_DATA_W-1:0] decim,
                             input logic [CFG_DATA_W-1:0] taps, input bit touch_unmapped);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INTERP;
    cfg_data  <= interp;
    @(posedge clk);
    reg_interp = interp[IFACT_W-1:0];
    cfg_index <= CFG_DECIM;
    cfg_data  <= decim;
    @(posedge clk);
    reg_decim = decim[DFACT_W-1:0];
    cfg_index <= CFG_TAPS;
    cfg_data  <= taps;
    @(posedge clk);
    reg_taps = taps[TFACT_W-1:0];
    if (touch_unmapped) begin
      cfg_index <= CFG_UNMAPPED;
      cfg_data  <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    load_prototype();
  endtask

  // mostly small factors, now and then an edge or out-of-range value per register
  task automatic random_reconfigure();
    logic [CFG_DATA_W-1:0] iv, dv, tv;
    iv = CFG_DATA_W'($urandom_range(6, 1));
    dv = CFG_DATA_W'($urandom_range(6, 1));
    tv = CFG_DATA_W'($urandom_range(6, 1));
    if ($urandom_range(6) == 0) begin
      case ($urandom_range(3))
        0: iv = 7'd0;
        1: iv = 7'd32;
        2: iv = 7'd40;
        default: iv = 7'd63;
      endcase
    end
    if ($urandom_range(6) == 0) begin
      case ($urandom_range(3))
        0: dv = 7'd0;
        1: dv = 7'd64;
        2: dv = 7'd100;
        default: dv = 7'd127;
      endcase
    end
    if ($urandom_range(6) == 0) begin
      case ($urandom_range(3))
        0: tv = 7'd0;
        1: tv = 7'd32;
        2: tv = 7'd50;
        default: tv = 7'd63;
      endcase
    end
    // a wide branch with long taps would need a large prototype load
    if (clamp_factor(iv[IFACT_W-1:0], MAX_BRANCHES) *
        clamp_factor(tv[TFACT_W-1:0], HIST_DEPTH) > RANDOM_REACH) tv = 7'd1;
    reconfigure(iv, dv, tv, $urandom_range(3) == 0);
  endtask

  // reset setting I = D = T = 1: plain scaling by tap 0, rounding and clipping
  task automatic test_reset_settings();
    send_tap(10'd0, 18'sh1FFFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_tap(10'd0, 18'sh20000);
    send_sample(16'sh8000);
    send_sample(16'sh0001);
    send_tap(10'd0, 18'sh00001);
    send_sample(16'shFFFF);
  endtask

  // zero factors act as 1; decimation above interpolation drops some samples silently
  task automatic test_small_factors();
    reconfigure(7'd0, 7'd0, 7'd0, 1'b0);
    send_sample(16'sh4000);
    reconfigure(7'd2, 7'd3, 7'd2, 1'b0);
    repeat (4) send_sample(random_sample());
    reconfigure(7'd3, 7'd1, 7'd2, 1'b0);
    repeat (2) send_sample(random_sample());
  endtask

  // largest and out-of-range settings: all branches, longest branch, widest step
  task automatic test_largest_sizes();
    recv_stall_pct = 34;
    reconfigure(7'd63, 7'd0, 7'd1, 1'b1);
    repeat (2) send_sample(random_sample());
    reconfigure(7'd1, 7'd127, 7'd63, 1'b0);
    repeat (3) send_sample(random_sample());
    reconfigure(7'd32, 7'd64, 7'd0, 1'b0);
    send_sample(16'sh7FFF);
    repeat (2) send_sample(random_sample());
    recv_stall_pct = 0;
  endtask

  task automatic random_burst(input int n_items);
    int i, roll;
    for (i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      if (roll < 5) random_reconfigure();
      else if (roll < 20) send_tap(TAP_AW'($urandom_range(TAP_DEPTH - 1)), random_tap());
      else send_sample(random_sample());
    end
  endtask

  // random traffic under each idling pattern
  task automatic test_random_traffic();
    send_idle_pct = 0;  recv_stall_pct = 0;  random_burst(16);
    send_idle_pct = 72; recv_stall_pct = 0;  random_burst(16);
    send_idle_pct = 0;  recv_stall_pct = 72; random_burst(16);
    send_idle_pct = 34; recv_stall_pct = 34; random_burst(16);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  // receiver holds off while samples keep coming, the block must stall its input
  task automatic test_output_backpressure();
    reconfigure(7'd4, 7'd1, 7'd3, 1'b0);
    hold_request = HOLD_OFF_CYCLES;
    repeat (12) send_sample(random_sample());
  endtask

  // sender pauses until every result is back, then carries on with the same state
  task automatic test_sender_pause();
    reconfigure(7'd5, 7'd2, 7'd6, 1'b0);
    repeat (8) send_sample(random_sample());
    drain_block();
    repeat (8) send_sample(random_sample());
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      recv_ready <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request - 1;
      hold_request = 0;
      recv_ready <= 1'b0;
    end else begin
      recv_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin : check_results
    resampled_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_outputs.size() == 0) begin
        $error("unexpected result: out_sample %0d phase_used %0d last %0d",
               out_ch.out_sample, out_ch.phase_used, out_ch.last);
        error_count++;
      end else begin
        want = predicted_outputs.pop_front();
        if (out_ch.out_sample !== want.out_sample) begin
          $error("out_sample: expected %0d, got %0d", want.out_sample, out_ch.out_sample);
          error_count++;
        end
        if (out_ch.phase_used !== want.phase_used) begin
          $error("phase_used: expected %0d, got %0d", want.phase_used, out_ch.phase_used);
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int k;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_INTERP;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_SAMPLE;
    in_ch.sample    <= '0;
    in_ch.tap_index <= '0;
    in_ch.tap_value <= '0;
    for (k = 0; k < HIST_DEPTH; k++) history[k] = '0;
    for (k = 0; k < TAP_DEPTH; k++) begin
      proto_taps[k] = '0;
      tap_known[k] = 1'b0;
    end
    phase_acc  = 0;
    reg_interp = IFACT_W'(1);
    reg_decim  = DFACT_W'(1);
    reg_taps   = TFACT_W'(1);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_small_factors();
    test_largest_sizes();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();

    drain_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
